// ----- rtl/button_debounce_autorepeat_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce core
// Shared property forms; each use clocks on clk and holds off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH

// Same-cycle implication
`define BDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bda: same-cycle check failed");

// Next-cycle implication
`define BDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bda: next-cycle check failed");

`endif

// ----- rtl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// Widths, register map and shared types of the button debounce core.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

  // Timestamp, debounce timer, repeat rate, repeat counter and divider step widths
  localparam int TIME_W  = 32;
  localparam int DB_W    = 16;
  localparam int RATE_W  = 16;
  localparam int CNT_W   = 16;
  localparam int STEP_W  = $clog2(TIME_W + 1);

  // Configuration port
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_INVERT     = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [2:0] REG_REP_DELAY  = 3'd2;
  localparam logic [2:0] REG_REP_RATE   = 3'd3;
  localparam logic [2:0] REG_LONG_DELAY = 3'd4;

  // Reset values of the registers
  localparam logic [DB_W-1:0]   DEBOUNCE_RST   = DB_W'(25);
  localparam logic [TIME_W-1:0] REP_DELAY_RST  = TIME_W'(1000);
  localparam logic [RATE_W-1:0] REP_RATE_RST   = RATE_W'(200);
  localparam logic [TIME_W-1:0] LONG_DELAY_RST = TIME_W'(1000);

  // Register file contents as seen by the core
  typedef struct packed {
    logic              invert;
    logic [DB_W-1:0]   debounce_time;
    logic [TIME_W-1:0] repeat_delay;
    logic [RATE_W-1:0] repeat_rate;
    logic [TIME_W-1:0] long_press_delay;
  } bda_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bda_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bda_cfg_regs
// APB-style register file holding the debounce and repeat settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_cfg_regs
  import bda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output bda_cfg_t               cfg
);

  bda_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg        = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert           <= 1'b0;
      cfg_r.debounce_time    <= DEBOUNCE_RST;
      cfg_r.repeat_delay     <= REP_DELAY_RST;
      cfg_r.repeat_rate      <= REP_RATE_RST;
      cfg_r.long_press_delay <= LONG_DELAY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_INVERT:     cfg_r.invert           <= cfg_pwdata[0];
        REG_DEBOUNCE:   cfg_r.debounce_time    <= cfg_pwdata[DB_W-1:0];
        REG_REP_DELAY:  cfg_r.repeat_delay     <= cfg_pwdata[TIME_W-1:0];
        REG_REP_RATE:   cfg_r.repeat_rate      <= cfg_pwdata[RATE_W-1:0];
        REG_LONG_DELAY: cfg_r.long_press_delay <= cfg_pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_INVERT:     cfg_prdata = CFG_DW'(cfg_r.invert);
      REG_DEBOUNCE:   cfg_prdata = CFG_DW'(cfg_r.debounce_time);
      REG_REP_DELAY:  cfg_prdata = CFG_DW'(cfg_r.repeat_delay);
      REG_REP_RATE:   cfg_prdata = CFG_DW'(cfg_r.repeat_rate);
      REG_LONG_DELAY: cfg_prdata = CFG_DW'(cfg_r.long_press_delay);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bda_div.sv -----
// ----------------------------------------------------------------------------
// bda_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_div
  import bda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [RATE_W-1:0] divisor,
  output logic                   done,
  output logic      [TIME_W-1:0] quotient
);

  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [RATE_W-1:0] rem_r;
  logic [TIME_W-1:0] quo_r;
  logic [RATE_W-1:0] dsr_r;
  logic [RATE_W:0]   shifted;
  logic [RATE_W:0]   trial;

  // Shift in the next dividend bit and try a subtract
  assign shifted  = {rem_r, quo_r[TIME_W-1]};
  assign trial    = shifted - {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= STEP_W'(TIME_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == STEP_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      if (!trial[RATE_W]) begin
        rem_r <= trial[RATE_W-1:0];
        quo_r <= {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[RATE_W-1:0];
        quo_r <= {quo_r[TIME_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/button_debounce_autorepeat_core.sv -----
// Flow: a new input beat is accepted only once the previous sample's result has
//   been loaded into the output register. The 32-step bit-serial divider that
//   computes the auto-repeat cycle number runs for every sample. A result still
//   unread on the output holds the last step until out_tready frees it.
// Reset (rst_n low, synchronous): registers at defaults (invert 0, debounce 25,
//   repeat delay 1000, rate 200, long press 1000).
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core
// Timed push-button debouncer with toggle, auto-repeat and long-press outputs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_autorepeat_core_defines.svh"

module button_debounce_autorepeat_core
  import bda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // Result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [7:0]        out_tdata,  // [0] pressed, [1] press_edge,
                                             // [2] release_edge, [3] toggle_level,
                                             // [4] repeat_level, [5] long_press,
                                             // [7:6] zero
  // Configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  bda_cfg_t          cfg;
  state_t            state_r, state_nxt;

  // Sample registers
  logic              level_r;
  logic [TIME_W-1:0] now_r;

  // Button state
  logic              stable_r, stable_nxt;
  logic              db_active_r, db_active_nxt;
  logic [DB_W-1:0]   db_start_r, db_start_nxt;
  logic [TIME_W-1:0] change_time_r, change_time_nxt;
  logic              toggle_r, toggle_nxt;
  logic              repeat_out_r, repeat_out_nxt;
  logic [CNT_W-1:0]  repeat_cnt_r, repeat_cnt_nxt;

  // Per-item working registers
  logic              press_r, press_nxt;
  logic              release_r, release_nxt;
  logic [TIME_W-1:0] held_r, held_nxt;
  logic              ge_rep_r, ge_rep_nxt;
  logic              long_r, long_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_data_r, out_data_nxt;

  // Divider hookup
  logic              div_start;
  logic [TIME_W-1:0] div_dividend;
  logic [RATE_W-1:0] div_divisor;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;

  logic              in_fire;
  logic              out_free;
  logic [DB_W-1:0]   db_elapsed;
  logic [CNT_W-1:0]  rep_cycle;

  bda_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Cycle number divide: (held - repeat_delay) / max(rate, 1)
  assign div_start    = (state_r == ST_PREP);
  assign div_dividend = held_r - cfg.repeat_delay;
  assign div_divisor  = (cfg.repeat_rate == '0) ? RATE_W'(1) : cfg.repeat_rate;

  bda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};
  assign db_elapsed = now_r[DB_W-1:0] - db_start_r;
  assign rep_cycle  = div_quo[CNT_W-1:0] + CNT_W'(1);

  // Sequencer and state update
  always_comb begin
    state_nxt       = state_r;
    stable_nxt      = stable_r;
    db_active_nxt   = db_active_r;
    db_start_nxt    = db_start_r;
    change_time_nxt = change_time_r;
    toggle_nxt      = toggle_r;
    repeat_out_nxt  = repeat_out_r;
    repeat_cnt_nxt  = repeat_cnt_r;
    press_nxt       = press_r;
    release_nxt     = release_r;
    held_nxt        = held_r;
    ge_rep_nxt      = ge_rep_r;
    long_nxt        = long_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r & ~out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CALC;
        end
      end

      // Debounce, edges, toggle, hold time
      ST_CALC: begin
        if (db_active_r) begin
          if (level_r != stable_r) begin
            if (db_elapsed >= cfg.debounce_time) begin
              stable_nxt      = level_r;
              change_time_nxt = now_r;
              db_active_nxt   = 1'b0;
            end
          end else begin
            db_active_nxt = 1'b0;
          end
        end else if (level_r != stable_r) begin
          db_start_nxt  = now_r[DB_W-1:0];
          db_active_nxt = 1'b1;
        end
        press_nxt   = stable_nxt & ~stable_r;
        release_nxt = ~stable_nxt & stable_r;
        if (press_nxt) begin
          toggle_nxt = ~toggle_r;
        end
        held_nxt  = now_r - change_time_nxt;
        state_nxt = ST_PREP;
      end

      // Hold-time compares; divider starts here
      ST_PREP: begin
        ge_rep_nxt = (held_r >= cfg.repeat_delay);
        long_nxt   = stable_r & (held_r >= cfg.long_press_delay);
        state_nxt  = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end

      // Auto-repeat decision and result load
      ST_DONE: begin
        if (out_free) begin
          repeat_out_nxt = stable_r;
          if (stable_r) begin
            if (ge_rep_r && (repeat_cnt_r < rep_cycle) && repeat_out_r) begin
              repeat_out_nxt = 1'b0;
              repeat_cnt_nxt = repeat_cnt_r + CNT_W'(1);
            end
          end else begin
            repeat_cnt_nxt = '0;
          end
          out_data_nxt  = {long_r, repeat_out_nxt, toggle_r, release_r, press_r, stable_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stable_r      <= 1'b0;
      db_active_r   <= 1'b0;
      db_start_r    <= '0;
      change_time_r <= '0;
      toggle_r      <= 1'b0;
      repeat_out_r  <= 1'b0;
      repeat_cnt_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stable_r      <= stable_nxt;
      db_active_r   <= db_active_nxt;
      db_start_r    <= db_start_nxt;
      change_time_r <= change_time_nxt;
      toggle_r      <= toggle_nxt;
      repeat_out_r  <= repeat_out_nxt;
      repeat_cnt_r  <= repeat_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      level_r <= in_tdata[0] ^ cfg.invert;
      now_r   <= in_tdata[TIME_W:1];
    end
    press_r    <= press_nxt;
    release_r  <= release_nxt;
    held_r     <= held_nxt;
    ge_rep_r   <= ge_rep_nxt;
    long_r     <= long_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `BDA_ASSERT_NEXT(a_fire_calc, in_fire, state_r == ST_CALC)
  `BDA_ASSERT_NOW(a_done_in_div, div_done, state_r == ST_DIV)
  `BDA_ASSERT_NOW(a_edges_excl, out_valid_r, !(out_data_r[1] && out_data_r[2]))
  `BDA_ASSERT_NOW(a_rep_needs_press, out_valid_r && out_data_r[4], out_data_r[0])
  `BDA_ASSERT_NOW(a_long_needs_press, out_valid_r && out_data_r[5], out_data_r[0])

endmodule

`default_nettype wire

// ----- sim/bda_output_compare.sv -----
// ----------------------------------------------------------------------------
// bda_output_compare
// Watches the sample, result and register ports of the debounce core. Keeps
// its own copy of the registers and of the debounce, toggle, auto-repeat and
// long-press state, predicts the flags for every accepted sample and compares
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_output_compare
  import bda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [39:0]       in_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [7:0]        out_tdata,  // [0] pressed, [1] press_edge,
                                             // [2] release_edge, [3] toggle_level,
                                             // [4] repeat_level, [5] long_press,
                                             // [7:6] zero
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  input  wire logic              cfg_pready,
  output int                     fail_count,
  output int                     pending_results
);

  // Result flags, highest bit first in out_tdata
  typedef struct packed {
    logic [1:0] pad;
    logic       long_press;
    logic       repeat_level;
    logic       toggle_level;
    logic       release_edge;
    logic       press_edge;
    logic       pressed;
  } button_flags_t;

  // Register copy
  logic              invert_q;
  logic [DB_W-1:0]   debounce_q;
  logic [TIME_W-1:0] rep_delay_q;
  logic [RATE_W-1:0] rep_rate_q;
  logic [TIME_W-1:0] long_delay_q;

  // Button state copy
  logic              stable;
  logic              window_open;
  logic [DB_W-1:0]   window_start;
  logic [TIME_W-1:0] changed_at;
  logic              toggle_q;
  logic              rep_level_q;
  logic [CNT_W-1:0]  rep_count;

  button_flags_t     expected_button_flags[$];
  button_flags_t     seen, want;
  int                beat_no;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    beat_no         = 0;
  end

  // One sample through debounce, toggle, auto-repeat and long press
  function automatic button_flags_t debounce_and_repeat(input logic pin,
                                                        input logic [TIME_W-1:0] stamp);
    logic              lvl;
    logic              was_stable;
    logic              last_rep;
    logic [DB_W-1:0]   elapsed;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] quot;
    logic [CNT_W-1:0]  cycle_no;
    button_flags_t     r;
    lvl        = pin ^ invert_q;
    was_stable = stable;
    r          = '0;

    // debounce window on the low timer bits
    if (window_open) begin
      if (lvl != stable) begin
        elapsed = stamp[DB_W-1:0] - window_start;
        if (elapsed >= debounce_q) begin
          stable      = lvl;
          changed_at  = stamp;
          window_open = 1'b0;
        end
      end else begin
        window_open = 1'b0;
      end
    end else if (lvl != stable) begin
      window_start = stamp[DB_W-1:0];
      window_open  = 1'b1;
    end

    r.pressed      = stable;
    r.press_edge   = stable & ~was_stable;
    r.release_edge = ~stable & was_stable;
    if (r.press_edge) toggle_q = ~toggle_q;
    r.toggle_level = toggle_q;

    // auto-repeat: one-sample release per elapsed period
    held     = stamp - changed_at;
    last_rep = rep_level_q;
    r.repeat_level = stable;
    if (stable) begin
      if (held >= rep_delay_q) begin
        period   = (rep_rate_q == '0) ? TIME_W'(1) : TIME_W'(rep_rate_q);
        quot     = (held - rep_delay_q) / period;
        cycle_no = CNT_W'(quot + TIME_W'(1));
        if (rep_count < cycle_no && last_rep) begin
          r.repeat_level = 1'b0;
          rep_count      = rep_count + 1'b1;
        end
      end
    end else begin
      rep_count = '0;
    end
    rep_level_q = r.repeat_level;

    r.long_press = stable && (held >= long_delay_q);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      invert_q     <= 1'b0;
      debounce_q   <= DEBOUNCE_RST;
      rep_delay_q  <= REP_DELAY_RST;
      rep_rate_q   <= REP_RATE_RST;
      long_delay_q <= LONG_DELAY_RST;
      stable       = 1'b0;
      window_open  = 1'b0;
      window_start = '0;
      changed_at   = '0;
      toggle_q     = 1'b0;
      rep_level_q  = 1'b0;
      rep_count    = '0;
      expected_button_flags.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid === 1'b1 && out_tready) begin
        seen = button_flags_t'(out_tdata);
        beat_no++;
        if (expected_button_flags.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d arrived with nothing predicted: %b", beat_no, out_tdata);
        end else begin
          want = expected_button_flags.pop_front();
          if (seen !== want) begin
            fail_count++;
            // flags from bit 7 down: pad, long, repeat, toggle, release, press, pressed
            if (fail_count <= 10)
              $display("result beat %0d mismatch: expected %b, got %b", beat_no, want, seen);
          end
        end
      end

      // sample beat
      if (in_tvalid && in_tready === 1'b1)
        expected_button_flags.push_back(debounce_and_repeat(in_tdata[0], in_tdata[TIME_W:1]));

      // register write; unmapped indexes are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready === 1'b1) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_INVERT:     invert_q     <= cfg_pwdata[0];
          REG_DEBOUNCE:   debounce_q   <= cfg_pwdata[DB_W-1:0];
          REG_REP_DELAY:  rep_delay_q  <= cfg_pwdata[TIME_W-1:0];
          REG_REP_RATE:   rep_rate_q   <= cfg_pwdata[RATE_W-1:0];
          REG_LONG_DELAY: long_delay_q <= cfg_pwdata[TIME_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results = expected_button_flags.size();
  end

endmodule

`default_nettype wire

// ----- sim/button_debounce_autorepeat_core_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core_tb
// Drives timestamped pin samples into the debounce core: a directed run over
// the debounce window, repeat cycles and both timer wraps, then random phases
// of bouncy press/release sessions under changing register settings. A
// separate compare module predicts and checks every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_core_tb;
  import bda_pkg::*;

  localparam int         SAMPLE_TARGET = 650;
  localparam int         DRAIN_CYCLES  = 40;
  localparam logic [2:0] REG_SPARE_LO  = 3'd5;  // first unmapped register index
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata    = '0;  // [0] pin_level, [32:1] now_ms, [39:33] zero
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [7:0]        out_tdata;         // [0] pressed, [1] press_edge, [2] release_edge,
                                        // [3] toggle_level, [4] repeat_level,
                                        // [5] long_press, [7:6] zero
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int                fail_count;
  int                pending_results;

  // Sender state
  int                burst_left   = 0;
  int                samples_sent = 0;
  logic [TIME_W-1:0] clock_ms     = '0;
  logic              pin_flip     = 1'b0;
  logic              btn_down     = 1'b0;

  // Receiver stall pattern
  int                stall_mode   = 0;
  int                stall_left   = 0;

  button_debounce_autorepeat_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  bda_output_compare compare (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending_results
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: always ready, coin flip, mostly ready, or periodic stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= (stall_left % 32) >= 16;
    endcase
  end

  // One sample beat; lvl is the logical level, the pin carries it through invert
  task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, stamp, lvl ^ pin_flip};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  // Stop sending and let every predicted result come out
  task automatic go_quiet();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic inv, input logic [DB_W-1:0] deb,
                                input logic [TIME_W-1:0] dly, input logic [RATE_W-1:0] rate,
                                input logic [TIME_W-1:0] lng);
    write_reg(REG_INVERT, CFG_DW'(inv));
    write_reg(REG_DEBOUNCE, CFG_DW'(deb));
    write_reg(REG_REP_DELAY, dly);
    write_reg(REG_REP_RATE, CFG_DW'(rate));
    write_reg(REG_LONG_DELAY, lng);
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
    pin_flip = inv;
  endtask

  // A press or release with contact bounce, sometimes too short or pure noise
  task automatic run_session();
    int kind;
    int n;
    int step_max;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(2, 10)) begin
        case ($urandom_range(0, 2))
          0:       clock_ms += $urandom_range(0, 3);
          1:       clock_ms += $urandom_range(0, 70000);
          default: clock_ms += $urandom();
        endcase
        send_sample($urandom_range(0, 1) == 1, clock_ms);
      end
    end else begin
      btn_down = ~btn_down;
      repeat ($urandom_range(0, 4)) begin
        clock_ms += $urandom_range(0, 3);
        send_sample($urandom_range(0, 1) == 1, clock_ms);
      end
      n        = (kind == 1) ? $urandom_range(1, 3) : $urandom_range(3, 30);
      step_max = $urandom_range(1, 30);
      repeat (n) begin
        clock_ms += $urandom_range(0, step_max);
        send_sample(btn_down, clock_ms);
      end
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: bounce, press, repeat cycles, long press
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'd10);
    send_sample(1'b0, 32'd12);          // bounce closes the window
    send_sample(1'b1, 32'd20);
    send_sample(1'b1, 32'd44);          // one short of the debounce time
    send_sample(1'b1, 32'd45);          // press
    send_sample(1'b1, 32'd1044);
    send_sample(1'b1, 32'd1045);        // repeat delay and long press reached
    send_sample(1'b1, 32'd1046);
    send_sample(1'b1, 32'd1245);        // second repeat cycle
    send_sample(1'b1, 32'd1246);
    send_sample(1'b1, 32'd1645);
    send_sample(1'b1, 32'd1646);
    send_sample(1'b0, 32'd1700);
    send_sample(1'b0, 32'd1725);        // release
    // debounce window across the timer wrap
    send_sample(1'b1, 32'd65530);
    send_sample(1'b1, 32'd65540);
    send_sample(1'b1, 32'd65555);
    // held time across the timestamp wrap
    send_sample(1'b0, 32'hFFFF_FF00);
    send_sample(1'b0, 32'hFFFF_FF19);
    send_sample(1'b1, 32'hFFFF_FF20);
    send_sample(1'b1, 32'hFFFF_FF39);
    send_sample(1'b1, 32'h0000_0321);
    send_sample(1'b1, 32'hFFFF_FFFF);

    // Random phases; the first two use the lowest and highest settings
    phase    = 0;
    clock_ms = 32'd5000;
    while (samples_sent < SAMPLE_TARGET) begin
      go_quiet();
      case (phase)
        0: apply_settings(1'b1, '0, '0, '0, '0);
        1: apply_settings(1'b1, '1, '1, '1, '1);
        default:
          apply_settings($urandom_range(0, 1) == 1,
                         ($urandom_range(0, 7) == 0) ? DB_W'($urandom())
                                                     : DB_W'($urandom_range(0, 40)),
                         ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 400),
                         ($urandom_range(0, 7) == 0) ? RATE_W'($urandom())
                                                     : RATE_W'($urandom_range(0, 60)),
                         ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 500));
      endcase
      if ($urandom_range(0, 5) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
      phase_end = samples_sent + $urandom_range(40, 90);
      while (samples_sent < phase_end) run_session();
      phase++;
    end

    go_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
